// ----- design/psz_pkg.sv -----
// shared types and constants of the parking sensor zone filter
`default_nettype none
package psz_pkg;

  localparam int RAW_W  = 8;
  localparam int ZONE_W = 9;
  localparam int LAST_W = 10;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0]  DIV_STEPS     = CNT_W'(ZONE_W);
  localparam logic [RAW_W-1:0]  ACTIVE_CODE_A = 8'hEF;
  localparam logic [RAW_W-1:0]  ACTIVE_CODE_B = 8'hC7;
  localparam logic [LAST_W-1:0] NO_ZONE       = 10'h3FF;
  localparam logic [ZONE_W-1:0] HIST_RESET    = 9'd255;

  localparam logic [1:0] MODE_SUPPRESS = 2'd1;
  localparam logic [1:0] MODE_ALWAYS   = 2'd2;

  localparam logic [2:0] REG_OUTER_MIN    = 3'd0;
  localparam logic [2:0] REG_OUTER_STEP   = 3'd1;
  localparam logic [2:0] REG_INNER_MIN    = 3'd2;
  localparam logic [2:0] REG_INNER_STEP   = 3'd3;
  localparam logic [2:0] REG_DISPLAY_MODE = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  typedef struct packed {
    logic              sensing_on;
    logic              update_valid;
    logic [ZONE_W-1:0] left_zone;
    logic [ZONE_W-1:0] right_zone;
    logic              restore_default;
  } result_t;

endpackage
`default_nettype wire

// ----- design/psz_if.sv -----
// request channel interfaces for sensor frames and zone results
`default_nettype none
interface psz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_code;
  logic [7:0] outer_left_raw;
  logic [7:0] outer_right_raw;
  logic [7:0] middle_left_raw;
  logic [7:0] middle_right_raw;

  modport source (output valid, status_code, outer_left_raw, outer_right_raw,
                  middle_left_raw, middle_right_raw, input ready);
  modport sink (input valid, status_code, outer_left_raw, outer_right_raw,
                middle_left_raw, middle_right_raw, output ready);
endinterface

interface psz_out_if;
  logic       valid;
  logic       ready;
  logic       sensing_on;
  logic       update_valid;
  logic [8:0] left_zone;
  logic [8:0] right_zone;
  logic       restore_default;

  modport source (output valid, sensing_on, update_valid, left_zone, right_zone,
                  restore_default, input ready);
  modport sink (input valid, sensing_on, update_valid, left_zone, right_zone,
                restore_default, output ready);
endinterface
`default_nettype wire

// ----- design/psz_zone_lane.sv -----
// one zone lane: offset and bit-serial restoring division by the step
`default_nettype none
module psz_zone_lane (
  input  wire logic                        clk,
  input  wire psz_pkg::lane_ctl_t          ctl,
  input  wire logic [psz_pkg::RAW_W-1:0]   raw,
  input  wire logic [psz_pkg::RAW_W-1:0]   min_val,
  input  wire logic [psz_pkg::RAW_W-1:0]   step_val,
  output logic      [psz_pkg::ZONE_W-1:0]  zone
);

  logic [psz_pkg::RAW_W-1:0]  div_r;
  logic [psz_pkg::RAW_W-1:0]  rem_r;
  logic [psz_pkg::ZONE_W-1:0] quo_r;
  logic [psz_pkg::RAW_W-1:0]  div_eff;
  logic [psz_pkg::ZONE_W-1:0] top_sum;
  logic [psz_pkg::ZONE_W-1:0] start_val;
  logic [psz_pkg::ZONE_W-1:0] trial;
  logic [psz_pkg::ZONE_W-1:0] diff;
  logic                       fits;

  always_comb begin
    div_eff   = (step_val == '0) ? psz_pkg::RAW_W'(1) : step_val;
    top_sum   = {1'b0, raw} + {1'b0, div_eff};
    start_val = (top_sum < {1'b0, min_val}) ? '0 : top_sum - {1'b0, min_val};
    trial     = {rem_r, quo_r[psz_pkg::ZONE_W-1]};
    fits      = (trial >= {1'b0, div_r});
    diff      = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      div_r <= div_eff;
      rem_r <= '0;
      quo_r <= start_val;
    end else if (ctl.step) begin
      rem_r <= fits ? diff[psz_pkg::RAW_W-1:0] : trial[psz_pkg::RAW_W-1:0];
      quo_r <= {quo_r[psz_pkg::ZONE_W-2:0], fits};
    end
  end

  assign zone = quo_r;

endmodule
`default_nettype wire

// ----- design/psz_merge.sv -----
// merge stage: side minimum, median history, repeat suppression, sensing state
`default_nettype none
module psz_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire logic [psz_pkg::RAW_W-1:0]   status,
  input  wire logic [1:0]                  mode,
  input  wire logic [psz_pkg::ZONE_W-1:0]  zone_ol,
  input  wire logic [psz_pkg::ZONE_W-1:0]  zone_or,
  input  wire logic [psz_pkg::ZONE_W-1:0]  zone_ml,
  input  wire logic [psz_pkg::ZONE_W-1:0]  zone_mr,
  output psz_pkg::result_t                 res
);

  logic                       active_r;
  logic [psz_pkg::ZONE_W-1:0] lhist_r [3];
  logic [psz_pkg::ZONE_W-1:0] rhist_r [3];
  logic [psz_pkg::ZONE_W-1:0] lhist_nxt [3];
  logic [psz_pkg::ZONE_W-1:0] rhist_nxt [3];
  logic [1:0]                 ptr_r;
  logic [1:0]                 fill_r;
  logic [psz_pkg::LAST_W-1:0] last_left_r;
  logic [psz_pkg::LAST_W-1:0] last_right_r;
  logic [psz_pkg::ZONE_W-1:0] left_new;
  logic [psz_pkg::ZONE_W-1:0] right_new;
  logic [psz_pkg::ZONE_W-1:0] left_filt;
  logic [psz_pkg::ZONE_W-1:0] right_filt;
  logic                       is_active;
  logic                       suppress;
  logic                       show;

  function automatic logic [psz_pkg::ZONE_W-1:0] median3(
    input logic [psz_pkg::ZONE_W-1:0] a,
    input logic [psz_pkg::ZONE_W-1:0] b,
    input logic [psz_pkg::ZONE_W-1:0] c
  );
    logic [psz_pkg::ZONE_W-1:0] hi;
    logic [psz_pkg::ZONE_W-1:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (c >= hi) begin
      median3 = hi;
    end else if (c <= lo) begin
      median3 = lo;
    end else begin
      median3 = c;
    end
  endfunction

  always_comb begin
    is_active = (status == psz_pkg::ACTIVE_CODE_A) || (status == psz_pkg::ACTIVE_CODE_B);
    left_new  = (zone_ml < zone_ol) ? zone_ml : zone_ol;
    right_new = (zone_mr < zone_or) ? zone_mr : zone_or;
    for (int i = 0; i < 3; i++) begin
      lhist_nxt[i] = (ptr_r == 2'(i)) ? left_new  : lhist_r[i];
      rhist_nxt[i] = (ptr_r == 2'(i)) ? right_new : rhist_r[i];
    end
    if (fill_r > 2'd1) begin
      left_filt  = median3(lhist_nxt[0], lhist_nxt[1], lhist_nxt[2]);
      right_filt = median3(rhist_nxt[0], rhist_nxt[1], rhist_nxt[2]);
    end else begin
      left_filt  = left_new;
      right_filt = right_new;
    end
    suppress = (mode == psz_pkg::MODE_SUPPRESS) &&
               ({1'b0, left_filt} == last_left_r) &&
               ({1'b0, right_filt} == last_right_r);
    show = (mode == psz_pkg::MODE_SUPPRESS) || (mode == psz_pkg::MODE_ALWAYS);

    res = '0;
    if (!is_active) begin
      res.restore_default = active_r;
    end else begin
      res.sensing_on = 1'b1;
      if (!suppress && show) begin
        res.update_valid = 1'b1;
        res.left_zone    = left_filt;
        res.right_zone   = right_filt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      ptr_r        <= '0;
      fill_r       <= '0;
      last_left_r  <= '0;
      last_right_r <= '0;
      for (int i = 0; i < 3; i++) begin
        lhist_r[i] <= psz_pkg::HIST_RESET;
        rhist_r[i] <= psz_pkg::HIST_RESET;
      end
    end else if (fire) begin
      if (!is_active) begin
        if (active_r) begin
          active_r     <= 1'b0;
          last_left_r  <= psz_pkg::NO_ZONE;
          last_right_r <= psz_pkg::NO_ZONE;
          fill_r       <= '0;
          ptr_r        <= '0;
        end
      end else begin
        active_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          lhist_r[i] <= lhist_nxt[i];
          rhist_r[i] <= rhist_nxt[i];
        end
        if (fill_r <= 2'd1) begin
          fill_r <= fill_r + 2'd1;
        end
        ptr_r <= (ptr_r == 2'd2) ? 2'd0 : ptr_r + 2'd1;
        if (!suppress) begin
          last_left_r  <= {1'b0, left_filt};
          last_right_r <= {1'b0, right_filt};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/park_sensor_zone_filter_core.sv -----
// top level of the parking sensor zone filter with its register port
//
// One request on in_chan carries a sensor frame (status byte and four raw
// distances); each frame yields exactly one result request on out_chan.
// Four lanes turn the raw distances into zones at once, each with a
// bit-serial divider that takes one quotient bit per cycle; a frame passes
// through the lanes (ST_DIV) and then the merge stage (ST_MERGE) before
// its result is offered, and the next frame is accepted only once that
// frame's merge is done.
// in_chan.ready is high only while the lanes are free. A finished result
// sits in the output register; the next frame is accepted and divided while
// it waits, and that frame's merge holds until the output register frees.
// Registers sit on the APB-style port at byte addresses 0, 4, 8, 12, 16:
// outer_min, outer_step, inner_min, inner_step, display_mode.
// Reset (synchronous, active low) restores the register defaults, clears
// the filter history to 255 and the sensing state, and empties the output.
`default_nettype none
module park_sensor_zone_filter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  psz_in_if.sink           in_chan,
  psz_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MERGE
  } state_t;

  state_t                            state_r;
  logic [psz_pkg::CNT_W-1:0]         cnt_r;
  logic [psz_pkg::RAW_W-1:0]         status_r;
  logic                              out_valid_r;
  psz_pkg::result_t                  res_r;
  psz_pkg::result_t                  res_merge;
  psz_pkg::lane_ctl_t                lane_ctl;

  logic [psz_pkg::RAW_W-1:0]         outer_min_r;
  logic [psz_pkg::RAW_W-1:0]         outer_step_r;
  logic [psz_pkg::RAW_W-1:0]         inner_min_r;
  logic [psz_pkg::RAW_W-1:0]         inner_step_r;
  logic [1:0]                        display_mode_r;

  logic [psz_pkg::RAW_W-1:0]         lane_raw  [4];
  logic [psz_pkg::RAW_W-1:0]         lane_min  [4];
  logic [psz_pkg::RAW_W-1:0]         lane_step [4];
  logic [psz_pkg::ZONE_W-1:0]        lane_zone [4];

  logic accept;
  logic fire;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_min_r    <= 8'd25;
      outer_step_r   <= 8'd8;
      inner_min_r    <= 8'd25;
      inner_step_r   <= 8'd30;
      display_mode_r <= psz_pkg::MODE_SUPPRESS;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        psz_pkg::REG_OUTER_MIN:    outer_min_r    <= pwdata[7:0];
        psz_pkg::REG_OUTER_STEP:   outer_step_r   <= pwdata[7:0];
        psz_pkg::REG_INNER_MIN:    inner_min_r    <= pwdata[7:0];
        psz_pkg::REG_INNER_STEP:   inner_step_r   <= pwdata[7:0];
        psz_pkg::REG_DISPLAY_MODE: display_mode_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      psz_pkg::REG_OUTER_MIN:    prdata = {24'd0, outer_min_r};
      psz_pkg::REG_OUTER_STEP:   prdata = {24'd0, outer_step_r};
      psz_pkg::REG_INNER_MIN:    prdata = {24'd0, inner_min_r};
      psz_pkg::REG_INNER_STEP:   prdata = {24'd0, inner_step_r};
      psz_pkg::REG_DISPLAY_MODE: prdata = {30'd0, display_mode_r};
      default:                   prdata = '0;
    endcase
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign fire          = (state_r == ST_MERGE) && (!out_valid_r || out_chan.ready);
  assign lane_ctl.load = accept;
  assign lane_ctl.step = (state_r == ST_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      status_r    <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (out_chan.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            status_r <= in_chan.status_code;
            cnt_r    <= '0;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + psz_pkg::CNT_W'(1);
          if (cnt_r == psz_pkg::DIV_STEPS - psz_pkg::CNT_W'(1)) begin
            state_r <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (fire) begin
            res_r       <= res_merge;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    lane_raw[0]  = in_chan.outer_left_raw;
    lane_raw[1]  = in_chan.outer_right_raw;
    lane_raw[2]  = in_chan.middle_left_raw;
    lane_raw[3]  = in_chan.middle_right_raw;
    lane_min[0]  = outer_min_r;
    lane_min[1]  = outer_min_r;
    lane_min[2]  = inner_min_r;
    lane_min[3]  = inner_min_r;
    lane_step[0] = outer_step_r;
    lane_step[1] = outer_step_r;
    lane_step[2] = inner_step_r;
    lane_step[3] = inner_step_r;
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    psz_zone_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .raw      (lane_raw[g]),
      .min_val  (lane_min[g]),
      .step_val (lane_step[g]),
      .zone     (lane_zone[g])
    );
  end

  psz_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .status  (status_r),
    .mode    (display_mode_r),
    .zone_ol (lane_zone[0]),
    .zone_or (lane_zone[1]),
    .zone_ml (lane_zone[2]),
    .zone_mr (lane_zone[3]),
    .res     (res_merge)
  );

  assign out_chan.valid           = out_valid_r;
  assign out_chan.sensing_on      = res_r.sensing_on;
  assign out_chan.update_valid    = res_r.update_valid;
  assign out_chan.left_zone       = res_r.left_zone;
  assign out_chan.right_zone      = res_r.right_zone;
  assign out_chan.restore_default = res_r.restore_default;

`ifndef SYNTHESIS
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DIV))
    else $error("accepted frame did not start the lanes");

  a_merge_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (!out_valid_r || out_chan.ready))
    else $error("merge overwrote a pending result");

  a_restore_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.restore_default && (res_r.sensing_on || res_r.update_valid)))
    else $error("restore flagged on an active result");

  a_update_needs_sensing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.update_valid) |-> res_r.sensing_on)
    else $error("update without sensing");
`endif

endmodule
`default_nettype wire
